@@ hdl/tsc_pkg.sv @@
// Shared types and constants for the Taylor series sine/cosine block.
// Used by tsc_cell and taylor_sine_cosine; depends on nothing else.
`default_nettype none

package tsc_pkg;

  // Pi in unsigned Q3.28 and one in signed Q1.30.
  localparam logic [30:0] PI_Q28 = 31'd843314857;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // Register stages from the input of one series cell to its output.
  localparam int CELL_LAT = 4;

  typedef struct packed {
    logic valid;
    logic negative;
    logic clamped;
  } tsc_ctl_t;

endpackage

`default_nettype wire

@@ hdl/tsc_mul.sv @@
// Two-stage unsigned multiplier with round half up, right shift and saturation.
// Stand-alone; used by tsc_cell and taylor_sine_cosine.
`default_nettype none

module tsc_mul #(
  parameter int WIDTH = 40,
  parameter int SHIFT = 36
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic [WIDTH-1:0] p_o
);

  localparam int LO = (WIDTH + 1) / 2;
  localparam int HI = WIDTH - LO;
  localparam int PW = 2 * WIDTH + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (SHIFT - 1);

  logic [2*LO-1:0]  pll_r, pll_nxt;
  logic [WIDTH-1:0] plh_r, plh_nxt;
  logic [WIDTH-1:0] phl_r, phl_nxt;
  logic [2*HI-1:0]  phh_r, phh_nxt;
  logic [PW-1:0]    sum;
  logic [PW-1:0]    quo;
  logic [WIDTH-1:0] p_r, p_nxt;

  always_comb begin
    pll_nxt = (2 * LO)'(a_i[LO-1:0]) * (2 * LO)'(b_i[LO-1:0]);
    plh_nxt = WIDTH'(a_i[LO-1:0]) * WIDTH'(b_i[WIDTH-1:LO]);
    phl_nxt = WIDTH'(a_i[WIDTH-1:LO]) * WIDTH'(b_i[LO-1:0]);
    phh_nxt = (2 * HI)'(a_i[WIDTH-1:LO]) * (2 * HI)'(b_i[WIDTH-1:LO]);
  end

  always_comb begin
    sum = PW'(pll_r) + (PW'(plh_r) << LO) + (PW'(phl_r) << LO)
        + (PW'(phh_r) << (2 * LO)) + HALF;
    quo = sum >> SHIFT;
    p_nxt = (|quo[PW-1:WIDTH]) ? {WIDTH{1'b1}} : quo[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    pll_r <= pll_nxt;
    plh_r <= plh_nxt;
    phl_r <= phl_nxt;
    phh_r <= phh_nxt;
    p_r   <= p_nxt;
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

@@ hdl/tsc_acc.sv @@
// Registered saturating accumulate of one unsigned term into a signed sum.
// Stand-alone; used by tsc_cell and taylor_sine_cosine.
`default_nettype none

module tsc_acc #(
  parameter int WORK_WIDTH = 40,
  parameter bit SUB        = 1'b0
) (
  input  logic                         clk,
  input  logic signed [WORK_WIDTH-1:0] acc_i,
  input  logic        [WORK_WIDTH-1:0] term_i,
  output logic signed [WORK_WIDTH-1:0] acc_o
);

  localparam logic signed [WORK_WIDTH+1:0] ACC_MAX =
    $signed({3'b000, {(WORK_WIDTH-1){1'b1}}});
  localparam logic signed [WORK_WIDTH+1:0] ACC_MIN = -ACC_MAX;

  logic signed [WORK_WIDTH+1:0] term_sat;
  logic signed [WORK_WIDTH+1:0] sum;
  logic signed [WORK_WIDTH-1:0] acc_r, acc_nxt;

  always_comb begin
    term_sat = (term_i > ACC_MAX[WORK_WIDTH-1:0]) ? ACC_MAX : $signed({2'b00, term_i});
    if (SUB) begin
      sum = $signed({{2{acc_i[WORK_WIDTH-1]}}, acc_i}) - term_sat;
    end else begin
      sum = $signed({{2{acc_i[WORK_WIDTH-1]}}, acc_i}) + term_sat;
    end
    if (sum > ACC_MAX) begin
      acc_nxt = ACC_MAX[WORK_WIDTH-1:0];
    end else if (sum < ACC_MIN) begin
      acc_nxt = ACC_MIN[WORK_WIDTH-1:0];
    end else begin
      acc_nxt = sum[WORK_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_o = acc_r;

endmodule

`default_nettype wire

@@ hdl/tsc_cell.sv @@
// One series cell: adds or subtracts its sine and cosine terms and forms the next terms.
// Depends on tsc_pkg, tsc_mul and tsc_acc.
`default_nettype none

module tsc_cell import tsc_pkg::*; #(
  parameter int WORK_WIDTH = 40,
  parameter int INDEX      = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tsc_ctl_t                     ctl_i,
  input  logic        [WORK_WIDTH-1:0] x2_i,
  input  logic        [WORK_WIDTH-1:0] sterm_i,
  input  logic        [WORK_WIDTH-1:0] cterm_i,
  input  logic signed [WORK_WIDTH-1:0] sacc_i,
  input  logic signed [WORK_WIDTH-1:0] cacc_i,
  output tsc_ctl_t                     ctl_o,
  output logic        [WORK_WIDTH-1:0] x2_o,
  output logic        [WORK_WIDTH-1:0] sterm_o,
  output logic        [WORK_WIDTH-1:0] cterm_o,
  output logic signed [WORK_WIDTH-1:0] sacc_o,
  output logic signed [WORK_WIDTH-1:0] cacc_o
);

  localparam int FRAC_BITS = WORK_WIDTH - 4;
  localparam bit SUB = ((INDEX % 2) == 0);
  localparam logic [63:0] WORK_MASK = {64{1'b1}} >> (64 - WORK_WIDTH);
  localparam logic [63:0] SIN_DIV = 64'(2 * INDEX) * 64'(2 * INDEX + 1);
  localparam logic [63:0] COS_DIV = 64'(2 * INDEX - 1) * 64'(2 * INDEX);
  localparam logic [63:0] SIN_RECIP = WORK_MASK / SIN_DIV
    + (WORK_MASK % SIN_DIV + 64'd1 + SIN_DIV / 64'd2) / SIN_DIV;
  localparam logic [63:0] COS_RECIP = WORK_MASK / COS_DIV
    + (WORK_MASK % COS_DIV + 64'd1 + COS_DIV / 64'd2) / COS_DIV;

  tsc_ctl_t                     ctl_d_r  [CELL_LAT];
  logic        [WORK_WIDTH-1:0] x2_d_r   [CELL_LAT];
  logic signed [WORK_WIDTH-1:0] sacc_d_r [CELL_LAT-1];
  logic signed [WORK_WIDTH-1:0] cacc_d_r [CELL_LAT-1];
  logic signed [WORK_WIDTH-1:0] sacc_q;
  logic signed [WORK_WIDTH-1:0] cacc_q;
  logic        [WORK_WIDTH-1:0] srec_p;
  logic        [WORK_WIDTH-1:0] crec_p;

  tsc_acc #(.WORK_WIDTH(WORK_WIDTH), .SUB(SUB)) u_sacc (
    .clk(clk), .acc_i(sacc_i), .term_i(sterm_i), .acc_o(sacc_q)
  );

  tsc_acc #(.WORK_WIDTH(WORK_WIDTH), .SUB(SUB)) u_cacc (
    .clk(clk), .acc_i(cacc_i), .term_i(cterm_i), .acc_o(cacc_q)
  );

  tsc_mul #(.WIDTH(WORK_WIDTH), .SHIFT(WORK_WIDTH)) u_srec (
    .clk(clk), .a_i(sterm_i), .b_i(SIN_RECIP[WORK_WIDTH-1:0]), .p_o(srec_p)
  );

  tsc_mul #(.WIDTH(WORK_WIDTH), .SHIFT(WORK_WIDTH)) u_crec (
    .clk(clk), .a_i(cterm_i), .b_i(COS_RECIP[WORK_WIDTH-1:0]), .p_o(crec_p)
  );

  tsc_mul #(.WIDTH(WORK_WIDTH), .SHIFT(FRAC_BITS)) u_sx2 (
    .clk(clk), .a_i(srec_p), .b_i(x2_d_r[1]), .p_o(sterm_o)
  );

  tsc_mul #(.WIDTH(WORK_WIDTH), .SHIFT(FRAC_BITS)) u_cx2 (
    .clk(clk), .a_i(crec_p), .b_i(x2_d_r[1]), .p_o(cterm_o)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CELL_LAT; k++) begin
        ctl_d_r[k] <= '0;
      end
    end else begin
      ctl_d_r[0] <= ctl_i;
      for (int k = 1; k < CELL_LAT; k++) begin
        ctl_d_r[k] <= ctl_d_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    x2_d_r[0]   <= x2_i;
    sacc_d_r[0] <= sacc_q;
    cacc_d_r[0] <= cacc_q;
    for (int k = 1; k < CELL_LAT; k++) begin
      x2_d_r[k] <= x2_d_r[k-1];
    end
    for (int k = 1; k < CELL_LAT - 1; k++) begin
      sacc_d_r[k] <= sacc_d_r[k-1];
      cacc_d_r[k] <= cacc_d_r[k-1];
    end
  end

  assign ctl_o  = ctl_d_r[CELL_LAT-1];
  assign x2_o   = x2_d_r[CELL_LAT-1];
  assign sacc_o = sacc_d_r[CELL_LAT-2];
  assign cacc_o = cacc_d_r[CELL_LAT-2];

endmodule

`default_nettype wire

@@ hdl/taylor_sine_cosine.sv @@
// Taylor series sine/cosine top level: angle clamp, x squared, cell chain, output.
// Depends on tsc_pkg, tsc_mul, tsc_acc and tsc_cell.
`default_nettype none

// The block takes one angle per clock cycle and never stalls: busy stays low, and
// a request is taken at every edge where start is high. Each request yields one
// result, marked by out_valid for one cycle, in request order. Between request and
// result lie the chain of TERMS-1 series cells, four register stages each, plus
// the clamp stage, the two-stage x squared multiplier, the last accumulate and
// the output register. The receiver must take every result as it appears.
module taylor_sine_cosine import tsc_pkg::*; #(
  parameter int TERMS      = 24,
  parameter int WORK_WIDTH = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_angle,
  output logic               out_valid,
  output logic signed [31:0] out_sine_value,
  output logic signed [31:0] out_cosine_value,
  output logic               out_clamped
);

  localparam int FRAC_BITS = WORK_WIDTH - 4;
  localparam int LATENCY   = CELL_LAT * TERMS + 1;
  localparam bit LAST_SUB  = ((TERMS % 2) == 0);
  localparam logic [WORK_WIDTH-1:0] ONE_TERM = WORK_WIDTH'(1) << FRAC_BITS;
  localparam int RND_SHIFT = (FRAC_BITS > 30) ? FRAC_BITS - 30 : 0;
  localparam int LSH       = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
  localparam logic [WORK_WIDTH+1:0] RND_HALF =
    (FRAC_BITS > 30) ? ((WORK_WIDTH + 2)'(1) << ((FRAC_BITS > 30) ? FRAC_BITS - 31 : 0))
                     : '0;

  function automatic logic signed [31:0] to_q30(input logic signed [WORK_WIDTH-1:0] v);
    logic [WORK_WIDTH+1:0] m;
    m = v[WORK_WIDTH-1] ? (WORK_WIDTH + 2)'(-v) : (WORK_WIDTH + 2)'(v);
    m = ((m + RND_HALF) >> RND_SHIFT) << LSH;
    if (m > (WORK_WIDTH + 2)'(ONE_Q30)) begin
      m = (WORK_WIDTH + 2)'(ONE_Q30);
    end
    return v[WORK_WIDTH-1] ? -$signed(32'(m)) : $signed(32'(m));
  endfunction

  logic                  accept;
  logic [30:0]           ang_abs;
  logic                  over;
  logic [30:0]           mag_clamp;
  tsc_ctl_t              ctl0_r, ctl0_nxt;
  logic [WORK_WIDTH-1:0] xm0_r, xm0_nxt;
  logic [WORK_WIDTH-1:0] x2;
  tsc_ctl_t              ctl1_r [2];
  logic [WORK_WIDTH-1:0] xm1_r  [2];

  tsc_ctl_t                     ch_ctl [TERMS];
  logic        [WORK_WIDTH-1:0] ch_x2  [TERMS];
  logic        [WORK_WIDTH-1:0] ch_st  [TERMS];
  logic        [WORK_WIDTH-1:0] ch_ct  [TERMS];
  logic signed [WORK_WIDTH-1:0] ch_sa  [TERMS];
  logic signed [WORK_WIDTH-1:0] ch_ca  [TERMS];

  tsc_ctl_t                     ctl2_r;
  logic signed [WORK_WIDTH-1:0] fin_s;
  logic signed [WORK_WIDTH-1:0] fin_c;
  logic signed [31:0]           sine_q30;
  logic                         out_valid_r;
  logic signed [31:0]           sine_r, sine_nxt;
  logic signed [31:0]           cosine_r, cosine_nxt;
  logic                         clamped_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    ang_abs   = in_angle[30] ? 31'(-in_angle) : 31'(in_angle);
    over      = ang_abs > PI_Q28;
    mag_clamp = over ? PI_Q28 : ang_abs;
    xm0_nxt   = WORK_WIDTH'(mag_clamp) << (FRAC_BITS - 28);
    ctl0_nxt.valid    = accept;
    ctl0_nxt.negative = in_angle[30];
    ctl0_nxt.clamped  = over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r    <= '0;
      ctl1_r[0] <= '0;
      ctl1_r[1] <= '0;
      ctl2_r    <= '0;
    end else begin
      ctl0_r    <= ctl0_nxt;
      ctl1_r[0] <= ctl0_r;
      ctl1_r[1] <= ctl1_r[0];
      ctl2_r    <= ch_ctl[TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    xm0_r    <= xm0_nxt;
    xm1_r[0] <= xm0_r;
    xm1_r[1] <= xm1_r[0];
  end

  tsc_mul #(.WIDTH(WORK_WIDTH), .SHIFT(FRAC_BITS)) u_x2 (
    .clk(clk), .a_i(xm0_r), .b_i(xm0_r), .p_o(x2)
  );

  assign ch_ctl[0] = ctl1_r[1];
  assign ch_x2[0]  = x2;
  assign ch_st[0]  = xm1_r[1];
  assign ch_ct[0]  = ONE_TERM;
  assign ch_sa[0]  = '0;
  assign ch_ca[0]  = '0;

  for (genvar g = 0; g < TERMS - 1; g++) begin : g_cell
    tsc_cell #(.WORK_WIDTH(WORK_WIDTH), .INDEX(g + 1)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ch_ctl[g]),
      .x2_i   (ch_x2[g]),
      .sterm_i(ch_st[g]),
      .cterm_i(ch_ct[g]),
      .sacc_i (ch_sa[g]),
      .cacc_i (ch_ca[g]),
      .ctl_o  (ch_ctl[g+1]),
      .x2_o   (ch_x2[g+1]),
      .sterm_o(ch_st[g+1]),
      .cterm_o(ch_ct[g+1]),
      .sacc_o (ch_sa[g+1]),
      .cacc_o (ch_ca[g+1])
    );
  end

  tsc_acc #(.WORK_WIDTH(WORK_WIDTH), .SUB(LAST_SUB)) u_fin_s (
    .clk(clk), .acc_i(ch_sa[TERMS-1]), .term_i(ch_st[TERMS-1]), .acc_o(fin_s)
  );

  tsc_acc #(.WORK_WIDTH(WORK_WIDTH), .SUB(LAST_SUB)) u_fin_c (
    .clk(clk), .acc_i(ch_ca[TERMS-1]), .term_i(ch_ct[TERMS-1]), .acc_o(fin_c)
  );

  always_comb begin
    sine_q30   = to_q30(fin_s);
    sine_nxt   = ctl2_r.negative ? -sine_q30 : sine_q30;
    cosine_nxt = to_q30(fin_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    sine_r    <= sine_nxt;
    cosine_r  <= cosine_nxt;
    clamped_r <= ctl2_r.clamped;
  end

  assign out_valid        = out_valid_r;
  assign out_sine_value   = sine_r;
  assign out_cosine_value = cosine_r;
  assign out_clamped      = clamped_r;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result strobe missing after request");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without matching request");

  a_clamp_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_angle > $signed(PI_Q28) || in_angle < -$signed(PI_Q28)))
    |-> ##LATENCY (out_valid && out_clamped))
    else $error("clamp flag lost for out of range angle");

  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine_value <= ONE_Q30 && out_sine_value >= -ONE_Q30
                   && out_cosine_value <= ONE_Q30 && out_cosine_value >= -ONE_Q30))
    else $error("result outside unit range");
`endif

endmodule

`default_nettype wire

@@ verif/taylor_sine_cosine_tb.sv @@
// Self-checking testbench for taylor_sine_cosine: directed and random angles in Q3.28, each result
// compared with a bit-exact fixed-point series model kept in the bench, the zero angle with typed values.
// Depends on tsc_pkg and the taylor_sine_cosine RTL.
`timescale 1ns / 1ps

module taylor_sine_cosine_tb;
  import tsc_pkg::*;

  localparam int TERMS = 24;
  localparam int WORK_WIDTH = 40;
  localparam int FRAC = WORK_WIDTH - 4;
  localparam int LATENCY = 4 * TERMS + 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIRECTED = 20;
  localparam int N_ITEMS = 1850;
  localparam logic [63:0] WORK_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - WORK_WIDTH);
  localparam longint ACC_MAX = longint'(WORK_MASK >> 1);
  localparam int PI_INT = 843314857;

  typedef struct packed {
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
    logic               clamped;
  } trig_t;

  typedef struct packed {
    logic signed [30:0] angle;
    logic               typed;
    trig_t              want;
  } vec_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [30:0] in_angle;
  logic out_valid;
  logic signed [31:0] out_sine_value;
  logic signed [31:0] out_cosine_value;
  logic out_clamped;

  trig_t trig_pending[$];
  logic  cur_typed;
  trig_t cur_want;
  int    n_requests;
  int    n_results;
  int    n_clamped;
  int    n_errors;
  int    idle_cycles;

  vec_t directed_tbl [N_DIRECTED] = '{
    '{31'sd0, 1'b1, '{32'sd0, ONE_Q30, 1'b0}},
    '{31'sd843314857, 1'b0, '0},
    '{-31'sd843314857, 1'b0, '0},
    '{31'sd843314858, 1'b0, '0},
    '{-31'sd843314858, 1'b0, '0},
    '{31'h3FFF_FFFF, 1'b0, '0},
    '{31'h4000_0000, 1'b0, '0},
    '{31'sd1, 1'b0, '0},
    '{-31'sd1, 1'b0, '0},
    '{31'sd421657428, 1'b0, '0},
    '{-31'sd421657428, 1'b0, '0},
    '{31'sd210828714, 1'b0, '0},
    '{31'sd268435456, 1'b0, '0},
    '{-31'sd268435456, 1'b0, '0},
    '{31'sd536870912, 1'b0, '0},
    '{31'sd805306368, 1'b0, '0},
    '{-31'sd805306368, 1'b0, '0},
    '{31'h2AAA_AAAA, 1'b0, '0},
    '{31'h5555_5555, 1'b0, '0},
    '{31'sd1000, 1'b0, '0}
  };

  taylor_sine_cosine #(
    .TERMS(TERMS),
    .WORK_WIDTH(WORK_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_angle(in_angle),
    .out_valid(out_valid),
    .out_sine_value(out_sine_value),
    .out_cosine_value(out_cosine_value),
    .out_clamped(out_clamped)
  );

  function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    if (p > {64'd0, WORK_MASK}) return WORK_MASK;
    return p[63:0];
  endfunction

  function automatic logic [63:0] recip_rom(input logic [63:0] d);
    return WORK_MASK / d + (WORK_MASK % d + 64'd1 + d / 64'd2) / d;
  endfunction

  function automatic longint sat_accum(input longint acc, input logic [63:0] mag,
                                       input bit subtract);
    longint t;
    t = (mag > (WORK_MASK >> 1)) ? ACC_MAX : longint'(mag);
    if (subtract) return (acc < -ACC_MAX + t) ? -ACC_MAX : acc - t;
    return (acc > ACC_MAX - t) ? ACC_MAX : acc + t;
  endfunction

  function automatic logic signed [31:0] to_q30(input longint v);
    logic [63:0] m;
    bit neg;
    neg = v < 0;
    m = neg ? 64'(-v) : 64'(v);
    if (FRAC > 30) m = (m + (64'd1 << (FRAC - 31))) >> (FRAC - 30);
    else if (FRAC < 30) m = m << (30 - FRAC);
    if (m > 64'd1073741824) m = 64'd1073741824;
    return neg ? -signed'(m[31:0]) : signed'(m[31:0]);
  endfunction

  function automatic trig_t predict_trig(input logic signed [30:0] ang);
    trig_t r;
    logic [63:0] mag, xm, x2, sterm, cterm, n;
    longint sacc, cacc;
    bit negative;
    negative = ang < 0;
    mag = negative ? 64'(-longint'(ang)) : 64'(longint'(ang));
    r.clamped = mag > 64'(PI_Q28);
    if (r.clamped) mag = 64'(PI_Q28);
    xm = mag << (FRAC - 28);
    x2 = round_mul(xm, xm, FRAC);
    sterm = xm;
    cterm = 64'd1 << FRAC;
    sacc = 0;
    cacc = 0;
    for (int i = 1; i <= TERMS; i++) begin
      n = 64'(2 * i);
      sacc = sat_accum(sacc, sterm, (i % 2) == 0);
      cacc = sat_accum(cacc, cterm, (i % 2) == 0);
      if (i < TERMS) begin
        sterm = round_mul(round_mul(sterm, recip_rom(n * (n + 64'd1)), WORK_WIDTH), x2, FRAC);
        cterm = round_mul(round_mul(cterm, recip_rom((n - 64'd1) * n), WORK_WIDTH), x2, FRAC);
      end
    end
    if (negative) sacc = -sacc;
    r.sine = to_q30(sacc);
    r.cosine = to_q30(cacc);
    return r;
  endfunction

  function automatic logic signed [30:0] random_angle();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      v = int'($urandom_range(0, 2 * PI_INT)) - PI_INT;
    end else if (sel < 80) begin
      v = int'($urandom());
    end else if (sel < 92) begin
      v = PI_INT + int'($urandom_range(0, 32)) - 16;
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = int'($urandom_range(0, 4095));
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v[30:0];
  endfunction

  task automatic issue_angle(input logic signed [30:0] a, input logic typed,
                             input trig_t want);
    int seen;
    seen = n_requests;
    cur_typed = typed;
    cur_want = want;
    start <= 1'b1;
    in_angle <= a;
    do @(negedge clk); while (n_requests == seen);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    trig_t p;
    if (rst_n && start && busy === 1'b0) begin
      if (cur_typed) begin
        p = cur_want;
      end else begin
        p = predict_trig(in_angle);
      end
      if (p.clamped) n_clamped++;
      trig_pending.push_back(p);
      n_requests++;
    end
  end

  always @(posedge clk) begin
    trig_t e;
    if (rst_n && out_valid === 1'b1) begin
      n_results++;
      if (trig_pending.size() == 0) begin
        $error("unexpected result: sine_value %0d cosine_value %0d clamped %0b",
               out_sine_value, out_cosine_value, out_clamped);
        n_errors++;
      end else begin
        e = trig_pending.pop_front();
        if (out_sine_value !== e.sine) begin
          $error("sine_value: expected %0d, got %0d", e.sine, out_sine_value);
          n_errors++;
        end
        if (out_cosine_value !== e.cosine) begin
          $error("cosine_value: expected %0d, got %0d", e.cosine, out_cosine_value);
          n_errors++;
        end
        if (out_clamped !== e.clamped) begin
          $error("clamped: expected %0b, got %0b", e.clamped, out_clamped);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int burst_left;
    int gap;
    rst_n = 1'b0;
    start = 1'b0;
    in_angle = '0;
    cur_typed = 1'b0;
    cur_want = '0;
    n_requests = 0;
    n_results = 0;
    n_clamped = 0;
    n_errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int k = 0; k < N_ITEMS; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      if (k < N_DIRECTED) begin
        issue_angle(directed_tbl[k].angle, directed_tbl[k].typed, directed_tbl[k].want);
      end else begin
        issue_angle(random_angle(), 1'b0, '0);
      end
    end
    start <= 1'b0;
    while (trig_pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    $display("Ran %0d angle requests (%0d beyond pi and clamped), %0d results checked.",
             n_requests, n_clamped, n_results);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
